@@ hw/rtl/sliding_window_spread_max_unit_assert.svh @@
// Assertion macros used by the sliding window spread max datapath.
`ifndef SLIDING_WINDOW_SPREAD_MAX_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_SPREAD_MAX_UNIT_ASSERT_SVH

// Same-cycle implication on aclk, off while aresetn is low.
`define SWSM_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on aclk, off while aresetn is low.
`define SWSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/swsm_pkg.sv @@
// Shared constants, entry layout and controller/datapath interface types.
package swsm_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int POS_W      = CNT_W;
    localparam int SAMPLE_W   = 31;
    localparam int WLEN_W     = 11;
    localparam int SPREAD_W   = 32;
    localparam int TDATA_W    = 32;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // Register word index taken from paddr[2]
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    // One candidate: arrival position and sample value
    typedef struct packed {
        logic [POS_W-1:0]    idx;
        logic [SAMPLE_W-1:0] val;
    } entry_t;

    // Which candidate queue the sequencer works on
    typedef enum logic {
        Q_MAX = 1'b0,
        Q_MIN = 1'b1
    } qsel_t;

    // Commands from the controller
    typedef struct packed {
        logic  load_in;
        logic  rd_tail;
        logic  evict;
        logic  pop;
        logic  push;
        logic  finish;
        qsel_t sel;
    } cmd_t;

    // Status back to the controller
    typedef struct packed {
        logic cnt_zero;
        logic evict_hit;
        logic pop_hit;
        logic last;
        logic out_free;
    } sts_t;

endpackage

@@ hw/rtl/sliding_window_spread_max_unit.sv @@
// Top level of the sliding window spread max unit: APB window register, controller, datapath.
// Each item steps through head eviction, tail pruning and push on the max queue, then on the
// min queue, then the spread update; each candidate evicted from a queue head or dropped from
// a queue tail adds another read and check. One item is in work at a time: s_tready stays low
// until the current item finishes. A result appears on m_tvalid the cycle after the last item finishes.
// aresetn (synchronous, active low) empties both queues, clears the sequence and sets window 1.
module sliding_window_spread_max_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // slave item channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [swsm_pkg::TDATA_W-1:0]       s_tdata,   // [30:0] sample, [31] zero
    input  logic                               s_tlast,
    // master result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [swsm_pkg::TDATA_W-1:0]       m_tdata,   // [31:0] max_spread
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [swsm_pkg::PADDR_W-1:0]       paddr,
    input  logic [swsm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [swsm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import swsm_pkg::*;

    logic [WLEN_W-1:0]   wlen_reg;
    logic [WLEN_W-1:0]   win_len;
    logic                reg_sel_wlen;
    cmd_t                cmd;
    sts_t                sts;

    assign pready       = 1'b1;
    assign reg_sel_wlen = (paddr[2] == REG_WINDOW_LENGTH);

    // Write the window length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= WLEN_W'(1);
        end else if (psel && penable && pwrite && pready && reg_sel_wlen) begin
            wlen_reg <= pwdata[WLEN_W-1:0];
        end
    end

    // Read back
    assign prdata = reg_sel_wlen ? {{(APB_DATA_W-WLEN_W){1'b0}}, wlen_reg} : '0;

    // Clamp the window to 1..MAX_WINDOW
    always_comb begin
        priority if (wlen_reg == '0) begin
            win_len = WLEN_W'(1);
        end else if (wlen_reg > WLEN_W'(MAX_WINDOW)) begin
            win_len = WLEN_W'(MAX_WINDOW);
        end else begin
            win_len = wlen_reg;
        end
    end

    swsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    swsm_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .win_len    (win_len),
        .in_sample  (s_tdata[SAMPLE_W-1:0]),
        .in_last    (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_spread (m_tdata)
    );

endmodule

@@ hw/rtl/swsm_ctrl.sv @@
// Sequencer that steps each item through eviction, tail pruning, push and spread update.
module swsm_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  swsm_pkg::sts_t  sts,
    output swsm_pkg::cmd_t  cmd
);
    import swsm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EV_RD,
        ST_EV_CHK,
        ST_TL_RD,
        ST_TL_CHK,
        ST_PUSH,
        ST_HD_RD,
        ST_HD_CHK
    } state_t;

    state_t state_reg, state_next;
    qsel_t  sel_reg, sel_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Decode commands and the next state
    always_comb begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        cmd         = '0;
        cmd.sel     = sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    sel_next    = Q_MAX;
                    state_next  = ST_EV_RD;
                end
            end
            ST_EV_RD: begin
                state_next = sts.cnt_zero ? ST_TL_RD : ST_EV_CHK;
            end
            ST_EV_CHK: begin
                if (sts.evict_hit) begin
                    cmd.evict  = 1'b1;
                    state_next = ST_EV_RD;
                end else begin
                    state_next = ST_TL_RD;
                end
            end
            ST_TL_RD: begin
                cmd.rd_tail = 1'b1;
                state_next  = sts.cnt_zero ? ST_PUSH : ST_TL_CHK;
            end
            ST_TL_CHK: begin
                if (sts.pop_hit) begin
                    cmd.pop    = 1'b1;
                    state_next = ST_TL_RD;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                cmd.push = 1'b1;
                if (sel_reg == Q_MAX) begin
                    sel_next   = Q_MIN;
                    state_next = ST_EV_RD;
                end else begin
                    state_next = ST_HD_RD;
                end
            end
            ST_HD_RD: begin
                state_next = ST_HD_CHK;
            end
            ST_HD_CHK: begin
                // hold while a final result cannot be placed yet
                if (!sts.last || sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and queue select
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= Q_MAX;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

@@ hw/rtl/swsm_dpath.sv @@
// Candidate queue memories, sequence counters, spread tracking and result register.
`include "sliding_window_spread_max_unit_assert.svh"

module swsm_dpath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  swsm_pkg::cmd_t                  cmd,
    output swsm_pkg::sts_t                  sts,
    input  logic [swsm_pkg::WLEN_W-1:0]     win_len,
    input  logic [swsm_pkg::SAMPLE_W-1:0]   in_sample,
    input  logic                            in_last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [swsm_pkg::SPREAD_W-1:0]   out_spread
);
    import swsm_pkg::*;

    entry_t mx_mem [MAX_WINDOW];
    entry_t mn_mem [MAX_WINDOW];
    entry_t mx_rd_reg, mn_rd_reg;

    logic [SAMPLE_W-1:0] sample_reg;
    logic                last_reg;

    logic [ADDR_W-1:0]   mx_head_reg, mn_head_reg;
    logic [CNT_W-1:0]    mx_cnt_reg, mn_cnt_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    filled_reg;
    logic signed [SPREAD_W-1:0] best_reg;
    logic                out_valid_reg;
    logic [SPREAD_W-1:0] out_data_reg;

    logic [CNT_W-1:0]    mx_cnt_m1, mn_cnt_m1;
    logic [ADDR_W-1:0]   mx_tail, mn_tail, mx_waddr, mn_waddr, mx_raddr, mn_raddr;
    entry_t              sel_rd;
    logic [POS_W-1:0]    age;
    logic [CNT_W-1:0]    filled_inc;
    logic                window_full;
    logic signed [SPREAD_W-1:0] spread;
    logic signed [SPREAD_W-1:0] best_next;
    logic                seq_end;

    // Tail, push and read addresses of both ring buffers
    assign mx_cnt_m1 = mx_cnt_reg - CNT_W'(1);
    assign mn_cnt_m1 = mn_cnt_reg - CNT_W'(1);
    assign mx_tail   = mx_head_reg + mx_cnt_m1[ADDR_W-1:0];
    assign mn_tail   = mn_head_reg + mn_cnt_m1[ADDR_W-1:0];
    assign mx_waddr  = mx_head_reg + mx_cnt_reg[ADDR_W-1:0];
    assign mn_waddr  = mn_head_reg + mn_cnt_reg[ADDR_W-1:0];
    assign mx_raddr  = (cmd.rd_tail && cmd.sel == Q_MAX) ? mx_tail : mx_head_reg;
    assign mn_raddr  = (cmd.rd_tail && cmd.sel == Q_MIN) ? mn_tail : mn_head_reg;

    // Max candidate memory
    always_ff @(posedge aclk) begin
        if (cmd.push && cmd.sel == Q_MAX) begin
            mx_mem[mx_waddr] <= '{idx: pos_reg, val: sample_reg};
        end
        mx_rd_reg <= mx_mem[mx_raddr];
    end

    // Min candidate memory
    always_ff @(posedge aclk) begin
        if (cmd.push && cmd.sel == Q_MIN) begin
            mn_mem[mn_waddr] <= '{idx: pos_reg, val: sample_reg};
        end
        mn_rd_reg <= mn_mem[mn_raddr];
    end

    // Capture the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sample_reg <= in_sample;
            last_reg   <= in_last;
        end
    end

    // Compare the entry just read against the window and the new sample
    assign sel_rd = (cmd.sel == Q_MAX) ? mx_rd_reg : mn_rd_reg;
    assign age    = pos_reg - sel_rd.idx;

    always_comb begin
        sts           = '0;
        sts.cnt_zero  = (cmd.sel == Q_MAX) ? (mx_cnt_reg == '0) : (mn_cnt_reg == '0);
        sts.evict_hit = (age >= win_len);
        sts.pop_hit   = (cmd.sel == Q_MAX) ? (sel_rd.val <= sample_reg)
                                           : (sel_rd.val >= sample_reg);
        sts.last      = last_reg;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // Spread of the current window and running best
    assign filled_inc  = (filled_reg < CNT_W'(MAX_WINDOW)) ? filled_reg + CNT_W'(1)
                                                           : filled_reg;
    assign window_full = (filled_inc >= win_len);
    assign spread      = $signed({1'b0, mx_rd_reg.val}) - $signed({1'b0, mn_rd_reg.val});
    assign best_next   = (window_full && spread > best_reg) ? spread : best_reg;
    assign seq_end     = cmd.finish && last_reg;

    // Advance or clear queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mx_head_reg <= '0;
            mx_cnt_reg  <= '0;
            mn_head_reg <= '0;
            mn_cnt_reg  <= '0;
        end else if (seq_end) begin
            mx_head_reg <= '0;
            mx_cnt_reg  <= '0;
            mn_head_reg <= '0;
            mn_cnt_reg  <= '0;
        end else if (cmd.sel == Q_MAX) begin
            if (cmd.evict) begin
                mx_head_reg <= mx_head_reg + ADDR_W'(1);
                mx_cnt_reg  <= mx_cnt_m1;
            end else if (cmd.pop) begin
                mx_cnt_reg  <= mx_cnt_m1;
            end else if (cmd.push) begin
                mx_cnt_reg  <= mx_cnt_reg + CNT_W'(1);
            end
        end else begin
            if (cmd.evict) begin
                mn_head_reg <= mn_head_reg + ADDR_W'(1);
                mn_cnt_reg  <= mn_cnt_m1;
            end else if (cmd.pop) begin
                mn_cnt_reg  <= mn_cnt_m1;
            end else if (cmd.push) begin
                mn_cnt_reg  <= mn_cnt_reg + CNT_W'(1);
            end
        end
    end

    // Update sequence counters and best spread at item end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            filled_reg <= '0;
            best_reg   <= '1;
        end else if (seq_end) begin
            pos_reg    <= '0;
            filled_reg <= '0;
            best_reg   <= '1;
        end else if (cmd.finish) begin
            pos_reg    <= pos_reg + POS_W'(1);
            filled_reg <= filled_inc;
            best_reg   <= best_next;
        end
    end

    // Result register: load on the last item, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (seq_end) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_end) begin
            out_data_reg <= best_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_spread = out_data_reg;

    `SWSM_ASSERT_HOLD(a_cnt_bound, 1'b1, (mx_cnt_reg <= CNT_W'(MAX_WINDOW)) && (mn_cnt_reg <= CNT_W'(MAX_WINDOW)), "candidate count above depth")
    `SWSM_ASSERT_HOLD(a_head_order, cmd.finish, mx_rd_reg.val >= mn_rd_reg.val, "window max below window min")
    `SWSM_ASSERT_NEXT(a_seq_clear, seq_end, (pos_reg == '0) && (filled_reg == '0) && (mx_cnt_reg == '0) && (mn_cnt_reg == '0) && (best_reg == '1), "sequence state not cleared")
    `SWSM_ASSERT_NEXT(a_out_load, seq_end, out_valid_reg, "result not presented after last item")

endmodule
